// ----- sv/ray_box_slab_test_defines.svh -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_defines
// assertion macros shared by the ray box slab test modules
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RBST_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rbst assertion failed");

`define RBST_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rbst assertion failed");

`else

`define RBST_ASSERT_IMPLIES(label, clk, rst_n, pre, post)

`define RBST_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- sv/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// widths, payload types and arithmetic helpers of the ray box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int COORD_W  = 32;
    localparam int EDGE_W   = 31;
    localparam int DLO_W    = 33;
    localparam int DHI_W    = 34;
    localparam int PROD_W   = 66;
    localparam int T_W      = 64;
    localparam int NUM_AXES = 3;

    localparam logic [EDGE_W-1:0] EDGE_RESET = 31'd65536;

    localparam logic signed [T_W-1:0] T_INF     = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_ZERO    = '0;

    typedef struct packed {
        logic signed [DLO_W-1:0]   d_lo;
        logic signed [DHI_W-1:0]   d_hi;
        logic signed [COORD_W-1:0] rcp;
    } axis_diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_lo;
        logic signed [PROD_W-1:0] p_hi;
    } axis_prod_t;

    typedef struct packed {
        logic signed [T_W-1:0] t_near;
        logic signed [T_W-1:0] t_far;
    } axis_span_t;

    typedef struct packed {
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
    } span_t;

    // clamp a q32.32 product to the signed 64-bit range
    function automatic logic signed [T_W-1:0] sat64(input logic signed [PROD_W-1:0] p);
        logic signed [T_W-1:0] r;
        if ((p[PROD_W-1:T_W-1] == '0) || (p[PROD_W-1:T_W-1] == '1)) begin
            r = p[T_W-1:0];
        end else if (p[PROD_W-1]) begin
            r = T_NEG_INF;
        end else begin
            r = T_INF;
        end
        return r;
    endfunction

    // narrow the running span by one axis
    function automatic span_t fold(input span_t s, input axis_span_t a);
        span_t                 r;
        logic signed [T_W-1:0] lo_cap;
        logic signed [T_W-1:0] hi_cap;
        lo_cap = ($signed(a.t_near) < $signed(s.tmax)) ? a.t_near : s.tmax;
        r.tmin = ($signed(s.tmin) > $signed(lo_cap)) ? s.tmin : lo_cap;
        hi_cap = ($signed(a.t_far) > $signed(r.tmin)) ? a.t_far : r.tmin;
        r.tmax = ($signed(s.tmax) < $signed(hi_cap)) ? s.tmax : hi_cap;
        return r;
    endfunction

endpackage

// ----- sv/rbst_sub_stage.sv -----
// ----------------------------------------------------------------------------
// rbst_sub_stage
// first pipeline stage: far corner and corner-to-origin differences per axis
// ----------------------------------------------------------------------------
module rbst_sub_stage (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic [9*rbst_pkg::COORD_W-1:0]                 in_data,
    input  logic [rbst_pkg::EDGE_W-1:0]                    box_edge,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output rbst_pkg::axis_diff_t [rbst_pkg::NUM_AXES-1:0]  out_diff
);

    logic                                          valid_reg;
    rbst_pkg::axis_diff_t [rbst_pkg::NUM_AXES-1:0] diff_reg;
    rbst_pkg::axis_diff_t [rbst_pkg::NUM_AXES-1:0] diff_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_diff  = diff_reg;

    always_comb begin
        logic signed [rbst_pkg::COORD_W-1:0] lo;
        logic signed [rbst_pkg::COORD_W-1:0] org;
        logic signed [rbst_pkg::DLO_W-1:0]   hi;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            lo  = in_data[a*rbst_pkg::COORD_W +: rbst_pkg::COORD_W];
            org = in_data[(a+3)*rbst_pkg::COORD_W +: rbst_pkg::COORD_W];
            hi  = rbst_pkg::DLO_W'(lo) + $signed({2'b00, box_edge});
            diff_next[a].d_lo = rbst_pkg::DLO_W'(lo) - rbst_pkg::DLO_W'(org);
            diff_next[a].d_hi = rbst_pkg::DHI_W'(hi) - rbst_pkg::DHI_W'(org);
            diff_next[a].rcp  = in_data[(a+6)*rbst_pkg::COORD_W +: rbst_pkg::COORD_W];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            diff_reg <= diff_next;
        end
    end

endmodule

// ----- sv/rbst_mul_stage.sv -----
// ----------------------------------------------------------------------------
// rbst_mul_stage
// two pipeline stages: slab products, then saturation and near/far ordering
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_defines.svh"

module rbst_mul_stage (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  rbst_pkg::axis_diff_t [rbst_pkg::NUM_AXES-1:0]  in_diff,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output rbst_pkg::axis_span_t [rbst_pkg::NUM_AXES-1:0]  out_span
);

    logic                                          prod_valid_reg;
    logic                                          span_valid_reg;
    logic                                          prod_ready;
    logic                                          span_ready;
    rbst_pkg::axis_prod_t [rbst_pkg::NUM_AXES-1:0] prod_reg;
    rbst_pkg::axis_prod_t [rbst_pkg::NUM_AXES-1:0] prod_next;
    rbst_pkg::axis_span_t [rbst_pkg::NUM_AXES-1:0] span_reg;
    rbst_pkg::axis_span_t [rbst_pkg::NUM_AXES-1:0] span_next;

    assign span_ready = !span_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || span_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = span_valid_reg;
    assign out_span   = span_reg;

    always_comb begin
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            prod_next[a].p_lo = rbst_pkg::PROD_W'(in_diff[a].d_lo)
                              * rbst_pkg::PROD_W'(in_diff[a].rcp);
            prod_next[a].p_hi = rbst_pkg::PROD_W'(in_diff[a].d_hi)
                              * rbst_pkg::PROD_W'(in_diff[a].rcp);
        end
    end

    always_comb begin
        logic signed [rbst_pkg::T_W-1:0] t1;
        logic signed [rbst_pkg::T_W-1:0] t2;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            t1 = rbst_pkg::sat64(prod_reg[a].p_lo);
            t2 = rbst_pkg::sat64(prod_reg[a].p_hi);
            if (t1 < t2) begin
                span_next[a].t_near = t1;
                span_next[a].t_far  = t2;
            end else begin
                span_next[a].t_near = t2;
                span_next[a].t_far  = t1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
            span_valid_reg <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (span_ready) begin
                span_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (prod_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (span_ready && prod_valid_reg) begin
            span_reg <= span_next;
        end
    end

    `RBST_ASSERT_IMPLIES(span_x_ordered, clk, rst_n, span_valid_reg, $signed(span_reg[0].t_near) <= $signed(span_reg[0].t_far))
    `RBST_ASSERT_IMPLIES(span_z_ordered, clk, rst_n, span_valid_reg, $signed(span_reg[2].t_near) <= $signed(span_reg[2].t_far))
    `RBST_ASSERT_NEXT(prod_held_on_stall, clk, rst_n, prod_valid_reg && !span_ready, prod_valid_reg && $stable(prod_reg))

endmodule

// ----- sv/rbst_slab_fold.sv -----
// ----------------------------------------------------------------------------
// rbst_slab_fold
// two pipeline stages: span narrowing over x and y, then z and the hit flag
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_defines.svh"

module rbst_slab_fold (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  rbst_pkg::axis_span_t [rbst_pkg::NUM_AXES-1:0]  in_span,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic                                           out_hit
);

    logic                 xy_valid_reg;
    logic                 hit_valid_reg;
    logic                 xy_ready;
    logic                 hit_ready;
    rbst_pkg::span_t      xy_reg;
    rbst_pkg::span_t      xy_next;
    rbst_pkg::axis_span_t z_reg;
    logic                 hit_reg;
    logic                 hit_next;

    assign hit_ready = !hit_valid_reg || out_ready;
    assign xy_ready  = !xy_valid_reg || hit_ready;
    assign in_ready  = xy_ready;
    assign out_valid = hit_valid_reg;
    assign out_hit   = hit_reg;

    always_comb begin
        rbst_pkg::span_t start;
        start.tmin = rbst_pkg::T_ZERO;
        start.tmax = rbst_pkg::T_INF;
        xy_next = rbst_pkg::fold(rbst_pkg::fold(start, in_span[0]), in_span[1]);
    end

    always_comb begin
        rbst_pkg::span_t s;
        s        = rbst_pkg::fold(xy_reg, z_reg);
        hit_next = $signed(s.tmin) < $signed(s.tmax);
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            xy_valid_reg  <= 1'b0;
            hit_valid_reg <= 1'b0;
        end else begin
            if (xy_ready) begin
                xy_valid_reg <= in_valid;
            end
            if (hit_ready) begin
                hit_valid_reg <= xy_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (xy_ready && in_valid) begin
            xy_reg <= xy_next;
            z_reg  <= in_span[2];
        end
        if (hit_ready && xy_valid_reg) begin
            hit_reg <= hit_next;
        end
    end

    `RBST_ASSERT_IMPLIES(xy_span_ordered, clk, rst_n, xy_valid_reg, $signed(xy_reg.tmin) <= $signed(xy_reg.tmax))
    `RBST_ASSERT_IMPLIES(xy_entry_ahead, clk, rst_n, xy_valid_reg, $signed(xy_reg.tmin) >= $signed(rbst_pkg::T_ZERO))

endmodule

// ----- sv/ray_box_slab_test.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test
// ray versus axis-aligned cube slab test, when not stalled one query per clock
// ----------------------------------------------------------------------------
// Accepts one query per cycle while s_tready is high and returns one hit
// flag per query, in order. The depth is set by the five register stages:
// differences, six signed multipliers of 33x32 or 34x32 bits, saturation
// and near/far ordering, the x/y span fold, and the z fold with the final
// compare. Backpressure travels stage by stage, so empty stages keep
// filling while the output is held. box_edge is taken from the register
// written through cfg_wr_en.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rbst_pkg::EDGE_W-1:0]   cfg_wr_data,   // box_edge
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // box_x, box_y, box_z, origin_x, origin_y, origin_z,
    // recip_dir_x, recip_dir_y, recip_dir_z
    input  logic [9*rbst_pkg::COORD_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata        // hit, zero fill
);

    logic [rbst_pkg::EDGE_W-1:0]                   edge_reg;
    logic                                          diff_valid;
    logic                                          diff_ready;
    rbst_pkg::axis_diff_t [rbst_pkg::NUM_AXES-1:0] diff;
    logic                                          span_valid;
    logic                                          span_ready;
    rbst_pkg::axis_span_t [rbst_pkg::NUM_AXES-1:0] span;
    logic                                          hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= rbst_pkg::EDGE_RESET;
        end else if (cfg_wr_en) begin
            edge_reg <= cfg_wr_data;
        end
    end

    rbst_sub_stage u_sub (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .box_edge  (edge_reg),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_diff  (diff)
    );

    rbst_mul_stage u_mul (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_diff   (diff),
        .out_valid (span_valid),
        .out_ready (span_ready),
        .out_span  (span)
    );

    rbst_slab_fold u_fold (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (span_valid),
        .in_ready  (span_ready),
        .in_span   (span),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit)
    );

    assign m_tdata = {7'b0, hit};

endmodule

// ----- tb/ray_box_slab_test_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_checker
// Watches the query and hit channels of the ray box slab test. Every query
// transfer is run through a local slab-method model with the box edge that
// is currently written, and the predicted hit flag is queued. Every hit
// transfer is compared in order against the queue, and each mismatch is
// counted for the top.
// ----------------------------------------------------------------------------
module ray_box_slab_test_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rbst_pkg::EDGE_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [9*rbst_pkg::COORD_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    output int                             mismatches,
    output int                             pending,
    output int                             hits_seen,
    output int                             misses_seen
);

    localparam int EXP_DEPTH = 64;

    logic [rbst_pkg::EDGE_W-1:0] box_edge_q;
    logic                        expected_hits[EXP_DEPTH];
    logic [5:0]                  wr_ptr;
    logic [5:0]                  rd_ptr;
    int                          fill;

    // q32.32 slab distance, clamped to the signed 64-bit range
    function automatic longint slab_distance(input logic signed [35:0] diff,
                                             input logic signed [31:0] recip);
        logic signed [71:0] prod;
        logic signed [71:0] top_lim;
        logic signed [71:0] bot_lim;
        prod    = diff * recip;
        top_lim = rbst_pkg::T_INF;
        bot_lim = rbst_pkg::T_NEG_INF;
        if (prod > top_lim) begin
            return rbst_pkg::T_INF;
        end else if (prod < bot_lim) begin
            return rbst_pkg::T_NEG_INF;
        end
        return prod[63:0];
    endfunction

    function automatic logic ray_hits_box(input logic [9*rbst_pkg::COORD_W-1:0] query,
                                          input logic [rbst_pkg::EDGE_W-1:0] box_edge);
        longint             t_enter;
        longint             t_exit;
        longint             t_a;
        longint             t_b;
        longint             t_near;
        longint             t_far;
        logic signed [35:0] corner_lo;
        logic signed [35:0] corner_hi;
        logic signed [35:0] org;
        logic signed [31:0] recip;
        t_enter = 0;
        t_exit  = rbst_pkg::T_INF;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            corner_lo = $signed(query[a*rbst_pkg::COORD_W +: rbst_pkg::COORD_W]);
            org       = $signed(query[(3+a)*rbst_pkg::COORD_W +: rbst_pkg::COORD_W]);
            recip     = $signed(query[(6+a)*rbst_pkg::COORD_W +: rbst_pkg::COORD_W]);
            corner_hi = corner_lo + $signed({5'b0, box_edge});
            t_a       = slab_distance(corner_lo - org, recip);
            t_b       = slab_distance(corner_hi - org, recip);
            t_near    = (t_a < t_b) ? t_a : t_b;
            t_far     = (t_a > t_b) ? t_a : t_b;
            if (t_near > t_exit) t_near = t_exit;
            if (t_near > t_enter) t_enter = t_near;
            if (t_far < t_enter) t_far = t_enter;
            if (t_far < t_exit) t_exit = t_far;
        end
        return t_enter < t_exit;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge aclk) begin
        logic want;
        if (!aresetn) begin
            box_edge_q <= rbst_pkg::EDGE_RESET;
            wr_ptr = '0;
            rd_ptr = '0;
            fill   = 0;
        end else begin
            if (cfg_wr_en) begin
                box_edge_q <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                if (fill == EXP_DEPTH) begin
                    note_mismatch("query transfer with too many hits outstanding");
                end else begin
                    expected_hits[wr_ptr] = ray_hits_box(s_tdata, box_edge_q);
                    wr_ptr = wr_ptr + 6'd1;
                    fill++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (fill == 0) begin
                    note_mismatch($sformatf("hit transfer %0b with no query pending",
                                            m_tdata[0]));
                end else begin
                    want   = expected_hits[rd_ptr];
                    rd_ptr = rd_ptr + 6'd1;
                    fill--;
                    if (m_tdata[0] !== want) begin
                        note_mismatch($sformatf("hit expected %0b actual %0b",
                                                want, m_tdata[0]));
                    end
                    if (want) hits_seen++;
                    else misses_seen++;
                end
            end
        end
        pending = fill;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ray box slab test. After reset a directed set
// of queries covers the field extremes, saturating products and parallel
// rays; random queries follow, mostly aimed near the box, across several box
// edge settings written between drained phases. Both channels stall at
// random except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb;

    localparam int ONE         = 65536;
    localparam int MAXC        = 32'sh7FFFFFFF;
    localparam int MINC        = 32'sh80000000;
    localparam int NUM_PHASES  = 5;
    localparam int PHASE_ITEMS = 350;
    localparam int CYCLE_LIMIT = 400000;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [rbst_pkg::EDGE_W-1:0]    cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [9*rbst_pkg::COORD_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;

    logic                           s_taken;
    int                             stall_pct;
    int                             cycle_count;
    int                             queries_sent;
    int                             mismatches;
    int                             pending;
    int                             hits_seen;
    int                             misses_seen;

    ray_box_slab_test dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    ray_box_slab_test_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .hits_seen   (hits_seen),
        .misses_seen (misses_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_taken     <= s_tvalid && s_tready;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d hits still pending", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [9*rbst_pkg::COORD_W-1:0] pack_query(input int bx, input int by,
                                                                  input int bz, input int ox,
                                                                  input int oy, input int oz,
                                                                  input int rx, input int ry,
                                                                  input int rz);
        return {rz, ry, rx, oz, oy, ox, bz, by, bx};
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return MINC;
                    1: return MAXC;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2: return $urandom;
            default: return int'($urandom_range(16 * ONE)) - 8 * ONE;
        endcase
    endfunction

    // ray placed near the box and mostly pointed at it
    function automatic logic [9*rbst_pkg::COORD_W-1:0] aimed_query();
        int corner[3];
        int org[3];
        int recip[3];
        for (int a = 0; a < 3; a++) begin
            corner[a] = int'($urandom_range(128 * ONE)) - 64 * ONE;
            if ($urandom_range(9) == 0) begin
                org[a]   = corner[a];
                recip[a] = $urandom_range(1) ? MAXC : MINC;
            end else begin
                org[a]   = corner[a] + int'($urandom_range(12 * ONE)) - 6 * ONE;
                recip[a] = int'($urandom_range(4 * ONE, 1));
                if ((org[a] > corner[a]) ^ ($urandom_range(99) < 15)) begin
                    recip[a] = -recip[a];
                end
            end
        end
        return pack_query(corner[0], corner[1], corner[2], org[0], org[1], org[2],
                          recip[0], recip[1], recip[2]);
    endfunction

    function automatic logic [9*rbst_pkg::COORD_W-1:0] random_query();
        logic [9*rbst_pkg::COORD_W-1:0] q;
        int                             kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            q = aimed_query();
        end else if (kind < 85) begin
            for (int f = 0; f < 9; f++) begin
                q[f*rbst_pkg::COORD_W +: rbst_pkg::COORD_W] = pick_coord();
            end
        end else begin
            for (int f = 0; f < 9; f++) begin
                q[f*rbst_pkg::COORD_W +: rbst_pkg::COORD_W] = $urandom;
            end
        end
        return q;
    endfunction

    task automatic send_query(input logic [9*rbst_pkg::COORD_W-1:0] q);
        while ($urandom_range(99) < stall_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        do @(negedge aclk); while (!s_taken);
        queries_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_box_edge(input logic [rbst_pkg::EDGE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [rbst_pkg::EDGE_W-1:0] edge_setting[NUM_PHASES];
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        stall_pct    = 37;
        queries_sent = 0;

        edge_setting[0] = rbst_pkg::EDGE_RESET;
        edge_setting[1] = 31'd1;
        edge_setting[2] = 31'h7FFFFFFF;
        edge_setting[3] = rbst_pkg::EDGE_W'($urandom_range(32'h7FFFFFFF, 1));
        edge_setting[4] = rbst_pkg::EDGE_W'(3 * ONE);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed queries at the reset edge
        send_query(pack_query(0, 0, 0, ONE/2, ONE/2, ONE/2, ONE, ONE, ONE));
        send_query(pack_query(0, 0, 0, -ONE, ONE/2, ONE/2, ONE, MAXC, MAXC));
        send_query(pack_query(0, 0, 0, -ONE, 0, 0, ONE, MAXC, MINC));
        send_query(pack_query(0, 0, 0, 0, ONE/2, ONE/2, ONE, MAXC, MAXC));
        send_query(pack_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_query(pack_query(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
        send_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(pack_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_query(pack_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC));
        send_query(pack_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC));
        send_query(pack_query(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC));
        send_query(pack_query(2*ONE, 2*ONE, 2*ONE, 0, 0, 0, -ONE, -ONE, -ONE));
        send_query(pack_query(2*ONE, 2*ONE, 2*ONE, 0, 0, 0, ONE, ONE, ONE));
        send_query(pack_query(-2*ONE, -2*ONE, -2*ONE, 0, 0, 0, -ONE, -ONE, -ONE));
        send_query(pack_query(0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE));
        send_query(pack_query(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_query(pack_query(ONE, ONE, ONE, 0, 0, 0, 1, 1, 1));
        send_query(pack_query(32'h55555555, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                              32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                              32'h55555555));
        send_query(pack_query(32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                              32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                              32'hAAAAAAAA));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                write_box_edge(edge_setting[phase]);
            end
            stall_pct = (phase == 2) ? 0 : 37;
            if (phase != 0) begin
                send_query(pack_query(0, 0, 0, -ONE, 0, 0, ONE, MAXC, MINC));
                send_query(pack_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_query(random_query());
            end
        end
        drain();

        $display("sent %0d ray queries over %0d box edge settings, extremes included",
                 queries_sent, NUM_PHASES);
        $display("checked %0d hits and %0d misses, %0d mismatches",
                 hits_seen, misses_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rbst_pkg.sv
sv/rbst_sub_stage.sv
sv/rbst_mul_stage.sv
sv/rbst_slab_fold.sv
sv/ray_box_slab_test.sv
tb/ray_box_slab_test_checker.sv
tb/tb.sv
